// ----- rtl/core/efp_pkg.sv -----
// shared types, constants and fixed-point helpers for the euler flux block
package efp_pkg;

  localparam int W = 32;
  localparam int F = 16;
  localparam int NB = W + F;
  localparam int SR = (W + F + 1) / 2;
  localparam int RW = SR + 3;
  localparam int XW = W + 3;
  localparam int CW = 2 * W;
  localparam int IN_DW = ((4 * W + 7) / 8) * 8;
  localparam int OUT_DW = ((11 * W + 7) / 8) * 8;

  localparam logic [XW:0] TWO_XW = {1'b1, {XW{1'b0}}};
  localparam logic [XW-1:0] RECIP5 = XW'(TWO_XW / 5);

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_DENS = 2'd1;
  localparam logic [1:0] ERR_PRES = 2'd2;
  localparam logic [1:0] ERR_SAT  = 2'd3;

  typedef logic signed [W-1:0] word_t;
  typedef logic signed [CW-1:0] dword_t;
  typedef logic [CW-1:0] mag_t;
  typedef logic [XW-1:0] xw_t;

  typedef struct packed {
    logic [W-1:0]  rem;
    logic [NB-1:0] num;
    logic [NB-1:0] quo;
    logic [W-1:0]  den;
  } div_t;

  typedef struct packed {
    logic [RW-1:0]   rem;
    logic [2*SR-1:0] rad;
    logic [SR-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } clp_t;

  typedef struct packed {
    logic   bad;
    logic   dir;
    logic   sat;
    logic   xneg;
    word_t  rho;
    word_t  mx;
    word_t  my;
    word_t  e;
    word_t  u;
    word_t  v;
    word_t  muu;
    word_t  mvv;
    word_t  myu;
    word_t  mxv;
    word_t  kin;
    word_t  p;
    word_t  ep;
    word_t  f1;
    word_t  f3;
    word_t  f6;
    word_t  f7;
    word_t  c2;
    word_t  c;
    dword_t pm1;
    dword_t pm2;
    dword_t pm3;
    dword_t pm4;
    xw_t    x;
    xw_t    est;
  } item_t;

  function automatic logic [W-1:0] mag_of(input word_t a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic clp_t clamp_mag(input logic neg, input mag_t mag);
    mag_t lim;
    mag_t m;
    clp_t r;
    lim = (mag_t'(1) << (W - 1)) - mag_t'(!neg);
    r.sat = mag > lim;
    m = r.sat ? lim : mag;
    r.val = neg ? word_t'(~m[W-1:0] + 1'b1) : word_t'(m[W-1:0]);
    return r;
  endfunction

  function automatic clp_t add_sat(input word_t a, input word_t b);
    logic [W:0] s;
    logic [W:0] m;
    s = {a[W-1], a} + {b[W-1], b};
    m = s[W] ? (~s + 1'b1) : s;
    return clamp_mag(s[W], mag_t'(m));
  endfunction

  function automatic clp_t sub_sat(input word_t a, input word_t b);
    logic [W:0] s;
    logic [W:0] m;
    s = {a[W-1], a} - {b[W-1], b};
    m = s[W] ? (~s + 1'b1) : s;
    return clamp_mag(s[W], mag_t'(m));
  endfunction

  function automatic clp_t mul_sat(input dword_t p);
    mag_t m;
    m = p[CW-1] ? (~p + 1'b1) : p;
    return clamp_mag(p[CW-1], m >> F);
  endfunction

  function automatic xw_t est5(input xw_t x);
    logic [2*XW-1:0] pr;
    pr = {{XW{1'b0}}, x} * {{XW{1'b0}}, RECIP5};
    return pr[2*XW-1:XW];
  endfunction

  function automatic xw_t fix5(input xw_t x, input xw_t est);
    xw_t r;
    r = x - ((est << 2) + est);
    return (r >= XW'(5)) ? est + 1'b1 : est;
  endfunction

endpackage

// ----- rtl/core/efp_div_cell.sv -----
// one restoring division step: one quotient bit per cell
module efp_div_cell (
  input  logic          clk,
  input  logic          ce,
  input  efp_pkg::div_t d_in,
  output efp_pkg::div_t d_out
);
  import efp_pkg::*;

  logic [W:0] r2;
  div_t       nx;

  always_comb begin
    nx = d_in;
    r2 = {d_in.rem, d_in.num[NB-1]};
    nx.num = {d_in.num[NB-2:0], 1'b0};
    if (r2 >= {1'b0, d_in.den}) begin
      nx.rem = W'(r2 - {1'b0, d_in.den});
      nx.quo = {d_in.quo[NB-2:0], 1'b1};
    end else begin
      nx.rem = r2[W-1:0];
      nx.quo = {d_in.quo[NB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_out <= nx;
    end
  end

endmodule

// ----- rtl/core/efp_sqrt_cell.sv -----
// one digit-by-digit square root step: one root bit per cell
module efp_sqrt_cell (
  input  logic         clk,
  input  logic         ce,
  input  efp_pkg::sq_t s_in,
  output efp_pkg::sq_t s_out
);
  import efp_pkg::*;

  logic [RW-1:0] r2;
  logic [RW-1:0] tr;
  sq_t           nx;

  always_comb begin
    nx = s_in;
    r2 = {s_in.rem[RW-3:0], s_in.rad[2*SR-1 -: 2]};
    tr = {1'b0, s_in.root, 2'b01};
    nx.rad = {s_in.rad[2*SR-3:0], 2'b00};
    if (r2 >= tr) begin
      nx.rem = r2 - tr;
      nx.root = {s_in.root[SR-2:0], 1'b1};
    end else begin
      nx.rem = r2;
      nx.root = {s_in.root[SR-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s_out <= nx;
    end
  end

endmodule

// ----- rtl/core/euler_flux_and_wave_speeds.sv -----
// top level: 2d euler physical flux and wave speeds, fully pipelined
// most of the pipeline is cell chains: the velocity dividers, the pressure over density divider, the root
// throughput: one transaction per cycle while the pipeline advances; every cell then takes a new operand each cycle
// the whole pipeline advances when the output register is empty or taken
// reset clears the valid bits only; no clearing pass; s_tready is low during reset
module euler_flux_and_wave_speeds (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // density, momentum_x, momentum_y, total_energy
  input  logic [efp_pkg::IN_DW-1:0]  s_tdata,
  // direction
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // flux_x_mass, flux_x_momx, flux_x_momy, flux_x_energy, flux_y_mass,
  // flux_y_momx, flux_y_momy, flux_y_energy, speed_minus, speed_normal, speed_plus
  output logic [efp_pkg::OUT_DW-1:0] m_tdata,
  // error_code
  output logic [1:0]                 m_tuser
);
  import efp_pkg::*;

  logic ce;
  item_t in_item;
  item_t st0, st1, st2, st3, st4, st5, st6, st7, st8, st9, st10, st11, st12, st13, st14;
  item_t n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11, n12, n13, n14;
  logic v0;
  logic [14:1] vs;
  logic [NB-1:0] va, vb;
  logic [SR-1:0] vc;
  item_t sba [NB];
  item_t sbb [NB];
  item_t sbc [SR];
  div_t au [NB+1];
  div_t av [NB+1];
  div_t bq [NB+1];
  sq_t  sq [SR+1];
  word_t un, o_sm, o_sn, o_sp;
  clp_t cs_m, cs_p;
  logic [1:0] o_code;
  logic [OUT_DW-1:0] o_data;

  assign ce = !m_tvalid || m_tready;
  assign s_tready = !rst && ce;

  always_comb begin
    in_item = '0;
    in_item.rho = s_tdata[W-1:0];
    in_item.mx  = s_tdata[2*W-1:W];
    in_item.my  = s_tdata[3*W-1:2*W];
    in_item.e   = s_tdata[4*W-1:3*W];
    in_item.dir = s_tuser;
    in_item.bad = s_tdata[W-1] || (s_tdata[W-1:0] == '0);
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      va <= '0;
      vb <= '0;
      vc <= '0;
      vs <= '0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      v0 <= s_tvalid;
      va <= {va[NB-2:0], v0};
      vs[10:1] <= {vs[9:1], va[NB-1]};
      vb <= {vb[NB-2:0], vs[10]};
      vs[13:11] <= {vs[12:11], vb[NB-1]};
      vc <= {vc[SR-2:0], vs[13]};
      vs[14] <= vc[SR-1];
      m_tvalid <= vs[14];
    end
  end

  // side data delay lines and explicit stages
  always_ff @(posedge clk) begin
    if (ce) begin
      st0 <= in_item;
      sba[0] <= st0;
      for (int k = 1; k < NB; k++) sba[k] <= sba[k-1];
      st1 <= n1;
      st2 <= n2;
      st3 <= n3;
      st4 <= n4;
      st5 <= n5;
      st6 <= n6;
      st7 <= n7;
      st8 <= n8;
      st9 <= n9;
      st10 <= n10;
      sbb[0] <= st10;
      for (int k = 1; k < NB; k++) sbb[k] <= sbb[k-1];
      st11 <= n11;
      st12 <= n12;
      st13 <= n13;
      sbc[0] <= st13;
      for (int k = 1; k < SR; k++) sbc[k] <= sbc[k-1];
      st14 <= n14;
      m_tdata <= o_data;
      m_tuser <= o_code;
    end
  end

  // velocity dividers
  always_comb begin
    au[0].rem = '0;
    au[0].num = {mag_of(st0.mx), {F{1'b0}}};
    au[0].quo = '0;
    au[0].den = st0.rho;
    av[0].rem = '0;
    av[0].num = {mag_of(st0.my), {F{1'b0}}};
    av[0].quo = '0;
    av[0].den = st0.rho;
  end

  for (genvar k = 0; k < NB; k++) begin : g_div_a
    efp_div_cell u_du (.clk(clk), .ce(ce), .d_in(au[k]), .d_out(au[k+1]));
    efp_div_cell u_dv (.clk(clk), .ce(ce), .d_in(av[k]), .d_out(av[k+1]));
  end

  always_comb begin
    clp_t cu, cv;
    n1 = sba[NB-1];
    cu = clamp_mag(n1.mx[W-1], mag_t'(au[NB].quo));
    cv = clamp_mag(n1.my[W-1], mag_t'(av[NB].quo));
    n1.u = cu.val;
    n1.v = cv.val;
    n1.sat = n1.sat | cu.sat | cv.sat;
  end

  always_comb begin
    n2 = st1;
    n2.pm1 = dword_t'(st1.mx) * dword_t'(st1.u);
    n2.pm2 = dword_t'(st1.my) * dword_t'(st1.v);
    n2.pm3 = dword_t'(st1.my) * dword_t'(st1.u);
    n2.pm4 = dword_t'(st1.mx) * dword_t'(st1.v);
  end

  always_comb begin
    clp_t c1, c2, c3, c4;
    n3 = st2;
    c1 = mul_sat(st2.pm1);
    c2 = mul_sat(st2.pm2);
    c3 = mul_sat(st2.pm3);
    c4 = mul_sat(st2.pm4);
    n3.muu = c1.val;
    n3.mvv = c2.val;
    n3.myu = c3.val;
    n3.mxv = c4.val;
    n3.sat = st2.sat | c1.sat | c2.sat | c3.sat | c4.sat;
  end

  // kinetic energy
  always_comb begin
    clp_t ks;
    logic [W-1:0] km;
    n4 = st3;
    ks = add_sat(st3.muu, st3.mvv);
    km = mag_of(ks.val) >> 1;
    n4.kin = ks.val[W-1] ? word_t'(~km + 1'b1) : word_t'(km);
    n4.sat = st3.sat | ks.sat;
  end

  always_comb begin
    clp_t ds;
    n5 = st4;
    ds = sub_sat(st4.e, st4.kin);
    n5.x = xw_t'({mag_of(ds.val), 1'b0});
    n5.xneg = ds.val[W-1];
    n5.sat = st4.sat | ds.sat;
  end

  always_comb begin
    n6 = st5;
    n6.est = est5(st5.x);
  end

  // pressure
  always_comb begin
    xw_t q5;
    n7 = st6;
    q5 = fix5(st6.x, st6.est);
    n7.p = st6.xneg ? word_t'(~q5[W-1:0] + 1'b1) : word_t'(q5[W-1:0]);
  end

  always_comb begin
    clp_t es, a1, a6;
    n8 = st7;
    es = add_sat(st7.e, st7.p);
    a1 = add_sat(st7.muu, st7.p);
    a6 = add_sat(st7.mvv, st7.p);
    n8.ep = es.val;
    n8.f1 = a1.val;
    n8.f6 = a6.val;
    n8.sat = st7.sat | es.sat | a1.sat | a6.sat;
  end

  always_comb begin
    n9 = st8;
    n9.pm1 = dword_t'(st8.ep) * dword_t'(st8.u);
    n9.pm2 = dword_t'(st8.ep) * dword_t'(st8.v);
  end

  always_comb begin
    clp_t c3, c7;
    n10 = st9;
    c3 = mul_sat(st9.pm1);
    c7 = mul_sat(st9.pm2);
    n10.f3 = c3.val;
    n10.f7 = c7.val;
    n10.sat = st9.sat | c3.sat | c7.sat;
  end

  // pressure over density, zero numerator for negative pressure
  always_comb begin
    bq[0].rem = '0;
    bq[0].num = {(st10.p[W-1] ? {W{1'b0}} : mag_of(st10.p)), {F{1'b0}}};
    bq[0].quo = '0;
    bq[0].den = st10.rho;
  end

  for (genvar k = 0; k < NB; k++) begin : g_div_b
    efp_div_cell u_dq (.clk(clk), .ce(ce), .d_in(bq[k]), .d_out(bq[k+1]));
  end

  always_comb begin
    clp_t qc;
    n11 = sbb[NB-1];
    qc = clamp_mag(1'b0, mag_t'(bq[NB].quo));
    n11.x = (xw_t'(qc.val) << 3) - xw_t'(qc.val);
    n11.sat = n11.sat | qc.sat;
  end

  always_comb begin
    n12 = st11;
    n12.est = est5(st11.x);
  end

  always_comb begin
    clp_t cc;
    n13 = st12;
    cc = clamp_mag(1'b0, mag_t'(fix5(st12.x, st12.est)));
    n13.c2 = cc.val;
    n13.sat = st12.sat | cc.sat;
  end

  // sound speed root
  always_comb begin
    sq[0].rem = '0;
    sq[0].rad = '0;
    sq[0].rad[NB-1:0] = {st13.c2, {F{1'b0}}};
    sq[0].root = '0;
  end

  for (genvar k = 0; k < SR; k++) begin : g_sqrt
    efp_sqrt_cell u_sq (.clk(clk), .ce(ce), .s_in(sq[k]), .s_out(sq[k+1]));
  end

  always_comb begin
    clp_t rc;
    n14 = sbc[SR-1];
    rc = clamp_mag(1'b0, mag_t'(sq[SR].root));
    n14.c = rc.val;
    n14.sat = n14.sat | rc.sat;
  end

  // wave speeds, error code and output packing
  always_comb begin
    un = st14.dir ? st14.v : st14.u;
    cs_m = sub_sat(un, st14.c);
    cs_p = add_sat(un, st14.c);
    o_sm = cs_m.val;
    o_sn = un;
    o_sp = cs_p.val;
    o_data = '0;
    if (st14.bad) begin
      o_code = ERR_DENS;
    end else begin
      if (st14.p[W-1]) begin
        o_code = ERR_PRES;
      end else if (st14.sat || cs_m.sat || cs_p.sat) begin
        o_code = ERR_SAT;
      end else begin
        o_code = ERR_OK;
      end
      o_data[11*W-1:0] = {o_sp, o_sn, o_sm, st14.f7, st14.f6, st14.mxv, st14.my,
                          st14.f3, st14.myu, st14.f1, st14.mx};
    end
  end

  property p_dens_zero;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser == ERR_DENS) |-> (m_tdata == '0);
  endproperty
  a_dens_zero: assert property (p_dens_zero)
    else $error("density error result carries nonzero data");

  property p_pres_speeds;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser == ERR_PRES) |->
        (m_tdata[9*W-1:8*W] == m_tdata[10*W-1:9*W]) &&
        (m_tdata[11*W-1:10*W] == m_tdata[10*W-1:9*W]);
  endproperty
  a_pres_speeds: assert property (p_pres_speeds)
    else $error("negative pressure result has distinct speeds");

  property p_ok_order;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser == ERR_OK) |->
        ($signed(m_tdata[9*W-1:8*W]) <= $signed(m_tdata[10*W-1:9*W])) &&
        ($signed(m_tdata[10*W-1:9*W]) <= $signed(m_tdata[11*W-1:10*W]));
  endproperty
  a_ok_order: assert property (p_ok_order)
    else $error("wave speeds out of order");

endmodule

// ----- verif/tb_euler_flux_and_wave_speeds.sv -----
// testbench for the euler flux and wave speed block: directed table plus random states
`timescale 1ns / 1ps

module tb_euler_flux_and_wave_speeds;
  import efp_pkg::*;

  localparam int N_RANDOM = 1000;
  localparam int LATENCY = 135;

  typedef struct {
    logic signed [31:0] rho, mx, my, e;
    logic dir;
  } state_t;

  typedef struct {
    logic signed [31:0] val [11];
    logic [1:0] code;
  } flux_t;

  typedef struct {
    state_t st;
    logic known;
    logic [1:0] code;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;
  logic [1:0] m_tuser;

  flux_t pending[$];
  int errors = 0;
  logic calm = 1'b0;
  row_t rows[$];
  string field_names [11] = '{"flux_x_mass", "flux_x_momx", "flux_x_momy", "flux_x_energy",
                              "flux_y_mass", "flux_y_momx", "flux_y_momy", "flux_y_energy",
                              "speed_minus", "speed_normal", "speed_plus"};

  always #4 clk = ~clk;

  euler_flux_and_wave_speeds dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  localparam longint MAXW = 64'sd2147483647;
  localparam longint MINW = -64'sd2147483648;

  logic was_clamped;

  function automatic longint clampw(longint v);
    if (v > MAXW) begin
      was_clamped = 1'b1;
      return MAXW;
    end
    if (v < MINW) begin
      was_clamped = 1'b1;
      return MINW;
    end
    return v;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    logic signed [127:0] pr;
    logic [127:0] m;
    logic neg;
    pr = 128'(a) * 128'(b);
    neg = pr[127];
    m = neg ? -pr : pr;
    m = m >> 16;
    if (m > 128'h80000000) return clampw(neg ? MINW - 1 : MAXW + 1);
    return clampw(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint fxdiv(longint a, longint b);
    logic [127:0] m;
    logic neg;
    neg = a < 0;
    m = 128'(neg ? -a : a);
    m = (m << 16) / 128'(b);
    if (m > 128'h80000000) return clampw(neg ? MINW - 1 : MAXW + 1);
    return clampw(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint ratio(longint a, longint n, longint d);
    longint m;
    m = (a < 0 ? -a : a) * n / d;
    return clampw(a < 0 ? -m : m);
  endfunction

  function automatic longint isqrt(longint x);
    logic [63:0] t, r, c;
    t = 64'(x) << 16;
    r = 0;
    for (int i = 47; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c <= 64'hFFFFFFFF && c * c <= t) r = c;
    end
    return clampw(longint'(r));
  endfunction

  function automatic flux_t euler_flux(state_t s);
    flux_t f;
    longint rho, mx, my, e, u, v, kin, p, ep, un, c;
    rho = s.rho; mx = s.mx; my = s.my; e = s.e;
    was_clamped = 1'b0;
    c = 0;
    for (int i = 0; i < 11; i++) f.val[i] = 0;
    f.code = ERR_OK;
    if (rho <= 0) begin
      f.code = ERR_DENS;
      return f;
    end
    u = fxdiv(mx, rho);
    v = fxdiv(my, rho);
    kin = ratio(clampw(fxmul(mx, u) + fxmul(my, v)), 1, 2);
    p = ratio(clampw(e - kin), 2, 5);
    ep = clampw(e + p);
    un = s.dir ? v : u;
    f.val[0] = mx;
    f.val[1] = clampw(fxmul(mx, u) + p);
    f.val[2] = fxmul(my, u);
    f.val[3] = fxmul(ep, u);
    f.val[4] = my;
    f.val[5] = fxmul(mx, v);
    f.val[6] = clampw(fxmul(my, v) + p);
    f.val[7] = fxmul(ep, v);
    if (p < 0) f.code = ERR_PRES;
    else c = isqrt(ratio(fxdiv(p, rho), 7, 5));
    f.val[8] = clampw(un - c);
    f.val[9] = un;
    f.val[10] = clampw(un + c);
    if (f.code == ERR_OK && was_clamped) f.code = ERR_SAT;
    return f;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($urandom_range(0, 20)) << 16;
      2: return -(32'($urandom_range(0, 20)) << 16);
      3: return $urandom_range(0, 32'h0002_0000);
      4: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom())};
    endcase
  endfunction

  function automatic state_t rand_state();
    state_t s;
    s.rho = $urandom_range(0, 9) == 0 ? rand_word() :
            ($urandom_range(0, 3) == 0 ? $urandom() & 32'h7fff_ffff :
             $urandom_range(32'h0000_2000, 32'h0008_0000));
    s.mx = rand_word();
    s.my = rand_word();
    s.e = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(0, 32'h0100_0000);
    s.dir = $urandom_range(0, 1);
    return s;
  endfunction

  function automatic row_t row(int rho, int mx, int my, int e, bit dir, bit known,
                               logic [1:0] code);
    row_t r;
    r.st.rho = rho; r.st.mx = mx; r.st.my = my; r.st.e = e; r.st.dir = dir;
    r.known = known; r.code = code;
    return r;
  endfunction

  task automatic send(state_t s);
    s_tdata <= {s.e, s.my, s.mx, s.rho};
    s_tuser <= s.dir;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending.push_back(euler_flux(s));
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 13) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  always @(negedge clk) m_tready <= rst ? 1'b0 : (calm || $urandom_range(0, 99) >= 13);

  always @(posedge clk) begin
    flux_t exp_f;
    logic signed [31:0] got;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $error("result transaction with none expected");
        errors++;
      end else begin
        exp_f = pending.pop_front();
        for (int i = 0; i < 11; i++) begin
          got = m_tdata[32*i +: 32];
          if (got !== exp_f.val[i]) begin
            $error("%s expected %0d got %0d", field_names[i], exp_f.val[i], got);
            errors++;
          end
        end
        if (m_tuser !== exp_f.code) begin
          $error("error_code expected %0d got %0d", exp_f.code, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    flux_t f;
    rows.push_back(row(0, 5, 5, 5, 0, 1, ERR_DENS));
    rows.push_back(row(-65536, 1, 1, 1, 1, 1, ERR_DENS));
    rows.push_back(row(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 1, ERR_DENS));
    rows.push_back(row(65536, 0, 0, 0, 0, 1, ERR_OK));
    rows.push_back(row(65536, 0, 0, 0, 1, 1, ERR_OK));
    rows.push_back(row(65536, 65536, 0, 0, 0, 1, ERR_PRES));
    rows.push_back(row(65536, 0, 0, -65536, 1, 1, ERR_PRES));
    rows.push_back(row(65536, 65536, 131072, 10 << 16, 0, 0, 0));
    rows.push_back(row(65536, -65536, -131072, 10 << 16, 1, 0, 0));
    rows.push_back(row(1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0));
    rows.push_back(row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0, 0));
    rows.push_back(row(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    rows.push_back(row(2 << 16, 3 << 16, -(1 << 16), 32'h7fff_ffff, 1, 0, 0));
    rows.push_back(row(1 << 12, 1 << 20, 1 << 20, 1 << 24, 0, 0, 0));
    rows.push_back(row(1 << 16, 0, 0, 32'h0000_0001, 0, 0, 0));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[k]) begin
      if (rows[k].known) begin
        f = euler_flux(rows[k].st);
        if (f.code !== rows[k].code) begin
          $error("table row %0d error_code expected %0d model %0d", k, rows[k].code, f.code);
          errors++;
        end
      end
      send(rows[k].st);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      calm <= (n >= 300 && n < 450);
      send(rand_state());
    end
    calm <= 1'b0;
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    if (errors == 0 && pending.size() == 0)
      $display("PASS euler_flux_and_wave_speeds");
    else
      $display("FAIL euler_flux_and_wave_speeds");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL euler_flux_and_wave_speeds");
    $finish;
  end
endmodule
